// File: sv/qapd_pkg.sv
// Shared types and constants for the attitude PD controller and motor mixer.
package qapd_pkg;

  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int DT_W    = 16;
  localparam int DIVD_W  = ERR_W + DT_W;
  localparam int ACC_W   = 51;
  localparam int CORR_W  = 14;
  localparam int MIX_W   = 19;
  localparam int MOTOR_W = 16;
  localparam int CNT_W   = 6;

  localparam int DIV_STEPS = DIVD_W;
  localparam int MUL_STEPS = GAIN_W;

  localparam int CORR_LIMIT = 6554;
  localparam int MOTOR_FULL = 32768;

  localparam logic signed [ACC_W-1:0]  SUM_HI   = ACC_W'(CORR_LIMIT * 32);
  localparam logic signed [ACC_W-1:0]  SUM_LO   = -SUM_HI;
  localparam logic signed [CORR_W-1:0] CORR_POS = CORR_W'(CORR_LIMIT);
  localparam logic signed [CORR_W-1:0] CORR_NEG = -CORR_POS;

  typedef enum logic [2:0] {
    REG_ROLL_SP  = 3'd0,
    REG_PITCH_SP = 3'd1,
    REG_ROLL_KP  = 3'd2,
    REG_ROLL_KD  = 3'd3,
    REG_PITCH_KP = 3'd4,
    REG_PITCH_KD = 3'd5,
    REG_BASE     = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_MULD,
    ST_MULP,
    ST_SAT,
    ST_MIX
  } state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic                    sub;
  } alu_req_t;

endpackage

// File: sv/qapd_alu.sv
// Shared wide adder and subtractor used for both division and multiplication steps.
module qapd_alu
  import qapd_pkg::*;
(
  input  alu_req_t                req,
  output logic signed [ACC_W-1:0] y
);

  always_comb begin
    if (req.sub) begin
      y = req.a - req.b;
    end else begin
      y = req.a + req.b;
    end
  end

endmodule

// File: sv/quad_attitude_pd_mixer.sv
// Top level: two-axis attitude PD controller with X motor mixing.
// Per axis, each input word passes through setup, divide, derivative multiply, proportional multiply
// and saturate, then the two axes are mixed; with a zero time step, divide and derivative multiply are skipped.
// A new input word is taken only in idle, after the previous word has been mixed.
// The next input word is taken while a finished output word still waits.
// Synchronous reset restores the register defaults and clears both stored errors.
module quad_attitude_pd_mixer
  import qapd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] roll_angle,
  input  logic signed [ANGLE_W-1:0] pitch_angle,
  input  logic [DT_W-1:0]           step_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [MOTOR_W-1:0]        motor_front_a,
  output logic [MOTOR_W-1:0]        motor_front_b,
  output logic [MOTOR_W-1:0]        motor_rear_a,
  output logic [MOTOR_W-1:0]        motor_rear_b
);

  state_t state, state_next;

  logic signed [ANGLE_W-1:0] roll_sp, pitch_sp;
  logic [GAIN_W-1:0]         roll_kp, roll_kd, pitch_kp, pitch_kd;
  logic [15:0]               base_level;
  logic signed [ERR_W-1:0]   last_roll_err, last_pitch_err;
  logic                      axis;

  logic signed [ANGLE_W-1:0] roll_r, pitch_r;
  logic [DT_W-1:0]           step_r;
  logic signed [ERR_W-1:0]   err_r;
  logic                      neg_r;
  logic [DIVD_W-1:0]         divd;
  logic [DT_W-1:0]           rem;
  logic [DIVD_W-1:0]         quo;
  logic [CNT_W-1:0]          cnt;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   mcand;
  logic [GAIN_W-1:0]         gshift;
  logic signed [CORR_W-1:0]  roll_adj, pitch_adj;

  alu_req_t                alu_req;
  logic signed [ACC_W-1:0] alu_y;

  logic                      in_acc, out_load;
  logic signed [ERR_W-1:0]   sp_sel, ang_sel, last_sel, err_now;
  logic signed [DIFF_W-1:0]  diff_now;
  logic [ERR_W-1:0]          mag_now;
  logic [GAIN_W-1:0]         kp_sel, kd_sel;
  logic [DT_W:0]             shifted;
  logic                      quo_bit;
  logic [DIVD_W-1:0]         quo_next;
  logic signed [ACC_W-1:0]   err_ext;
  logic signed [CORR_W-1:0]  corr_now;
  logic signed [MIX_W-1:0]   t_ext, cr_ext, cp_ext;

  function automatic logic [MOTOR_W-1:0] motor_clamp(input logic signed [MIX_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > MIX_W'(MOTOR_FULL)) begin
      return MOTOR_W'(MOTOR_FULL);
    end else begin
      return v[MOTOR_W-1:0];
    end
  endfunction

  qapd_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == ST_MIX) && (!out_valid || out_ready);

  // Per-axis operand selection, setup error terms, divide step terms, clamped correction and mix operands.
  always_comb begin
    sp_sel   = axis ? ERR_W'(pitch_sp) : ERR_W'(roll_sp);
    ang_sel  = axis ? ERR_W'(pitch_r) : ERR_W'(roll_r);
    last_sel = axis ? last_pitch_err : last_roll_err;
    kp_sel   = axis ? pitch_kp : roll_kp;
    kd_sel   = axis ? pitch_kd : roll_kd;
    err_now  = sp_sel - ang_sel;
    diff_now = DIFF_W'(err_now) - DIFF_W'(last_sel);
    mag_now  = diff_now[DIFF_W-1] ? ERR_W'(-diff_now) : ERR_W'(diff_now);
    err_ext  = ACC_W'(err_r);
    shifted  = {rem, divd[DIVD_W-1]};
    quo_bit  = !alu_y[ACC_W-1];
    quo_next = {quo[DIVD_W-2:0], quo_bit};
    if (acc > SUM_HI) begin
      corr_now = CORR_POS;
    end else if (acc < SUM_LO) begin
      corr_now = CORR_NEG;
    end else begin
      corr_now = CORR_W'(acc >>> 5);
    end
    t_ext  = MIX_W'({1'b0, base_level});
    cr_ext = MIX_W'(roll_adj);
    cp_ext = MIX_W'(pitch_adj);
  end

  // The adder serves a trial subtraction while dividing and shift-add or shift-subtract while multiplying.
  always_comb begin
    alu_req.a   = acc;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state)
      ST_DIV: begin
        alu_req.a   = ACC_W'(shifted);
        alu_req.b   = ACC_W'(step_r);
        alu_req.sub = 1'b1;
      end
      ST_MULD, ST_MULP: begin
        alu_req.a   = acc;
        alu_req.b   = gshift[0] ? mcand : '0;
        alu_req.sub = (state == ST_MULD) && neg_r;
      end
      default: begin
        alu_req.a   = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = (step_r != '0) ? ST_DIV : ST_MULP;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_MULD;
      end
      ST_MULD: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_MULP;
      end
      ST_MULP: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) state_next = ST_SAT;
      end
      ST_SAT: begin
        state_next = axis ? ST_MIX : ST_SETUP;
      end
      ST_MIX: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Registers, stored errors and handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      roll_sp        <= '0;
      pitch_sp       <= '0;
      roll_kp        <= 16'd768;
      roll_kd        <= 16'd128;
      pitch_kp       <= 16'd768;
      pitch_kd       <= 16'd128;
      base_level     <= 16'd16384;
      last_roll_err  <= '0;
      last_pitch_err <= '0;
      axis           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ROLL_SP:  roll_sp    <= cfg_data;
          REG_PITCH_SP: pitch_sp   <= cfg_data;
          REG_ROLL_KP:  roll_kp    <= cfg_data;
          REG_ROLL_KD:  roll_kd    <= cfg_data;
          REG_PITCH_KP: pitch_kp   <= cfg_data;
          REG_PITCH_KD: pitch_kd   <= cfg_data;
          REG_BASE:     base_level <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        axis <= 1'b0;
      end else if (state == ST_SAT) begin
        axis <= ~axis;
      end
      if (state == ST_SETUP) begin
        if (axis) begin
          last_pitch_err <= err_now;
        end else begin
          last_roll_err <= err_now;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      roll_r  <= roll_angle;
      pitch_r <= pitch_angle;
      step_r  <= step_time;
    end
    case (state)
      ST_SETUP: begin
        err_r  <= err_now;
        neg_r  <= diff_now[DIFF_W-1];
        divd   <= {mag_now, {DT_W{1'b0}}};
        rem    <= '0;
        quo    <= '0;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= ACC_W'(err_now);
        gshift <= kp_sel;
      end
      ST_DIV: begin
        rem  <= quo_bit ? alu_y[DT_W-1:0] : shifted[DT_W-1:0];
        quo  <= quo_next;
        divd <= {divd[DIVD_W-2:0], 1'b0};
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt    <= '0;
          mcand  <= ACC_W'(quo_next);
          gshift <= kd_sel;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      ST_MULD: begin
        acc <= alu_y;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cnt    <= '0;
          mcand  <= err_ext;
          gshift <= kp_sel;
        end else begin
          cnt    <= cnt + 1'b1;
          mcand  <= mcand <<< 1;
          gshift <= gshift >> 1;
        end
      end
      ST_MULP: begin
        acc    <= alu_y;
        mcand  <= mcand <<< 1;
        gshift <= gshift >> 1;
        cnt    <= cnt + 1'b1;
      end
      ST_SAT: begin
        if (axis) begin
          pitch_adj <= corr_now;
        end else begin
          roll_adj <= corr_now;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      motor_front_a <= motor_clamp(t_ext + cp_ext + cr_ext);
      motor_front_b <= motor_clamp(t_ext + cp_ext - cr_ext);
      motor_rear_a  <= motor_clamp(t_ext - cp_ext + cr_ext);
      motor_rear_b  <= motor_clamp(t_ext - cp_ext - cr_ext);
    end
  end

  // The partial remainder must stay below the divisor throughout the division.
  a_rem_below_dt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < step_r))
    else $error("partial remainder not below time step");

  // The roll and pitch corrections used for mixing stay within the clamp.
  a_corr_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MIX) |-> (roll_adj <= CORR_POS && roll_adj >= CORR_NEG
                           && pitch_adj <= CORR_POS && pitch_adj >= CORR_NEG))
    else $error("correction outside clamp");

  // Mixing a word returns the sequencer to idle with the output word presented.
  a_mix_done: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("mixed word not presented");

  // The front-a and rear-b motor commands never exceed full throttle.
  a_motor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_front_a <= MOTOR_W'(MOTOR_FULL) && motor_rear_b <= MOTOR_W'(MOTOR_FULL)))
    else $error("motor command above full");

endmodule
